// ===== rtl/chbd_pkg.sv =====
`default_nettype none

package chbd_pkg;

  localparam int unsigned HoldDepthDef = 32;

  typedef logic [7:0] byte_t;

  localparam byte_t ChCr = 8'h0D;
  localparam byte_t ChLf = 8'h0A;

  localparam logic [1:0] EndZeroChunk = 2'd0;
  localparam logic [1:0] EndRanOut    = 2'd1;
  localparam logic [1:0] EndNoHeader  = 2'd2;

  typedef struct packed {
    logic [31:0] acc;
    logic        closed;
    logic        begun;
  } size_t;

  function automatic logic is_ws(byte_t b);
    return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

  // bit 4 set: not a hex digit
  function automatic logic [4:0] hex_val(byte_t b);
    byte_t t;
    t = 8'h00;
    if ((b >= 8'h30) && (b <= 8'h39)) begin
      t = b - 8'h30;
      return {1'b0, t[3:0]};
    end else if ((b >= 8'h61) && (b <= 8'h66)) begin
      t = b - 8'h57;
      return {1'b0, t[3:0]};
    end else if ((b >= 8'h41) && (b <= 8'h46)) begin
      t = b - 8'h37;
      return {1'b0, t[3:0]};
    end
    return 5'h10;
  endfunction

  function automatic size_t size_char(size_t s, byte_t b);
    size_t      r;
    logic [4:0] d;
    r = s;
    d = hex_val(b);
    if (!s.closed && (s.begun || !is_ws(b))) begin
      if (d[4]) begin
        r.closed = 1'b1;
      end else begin
        r.begun = 1'b1;
        r.acc   = (s.acc > 32'h0FFF_FFFF) ? 32'hFFFF_FFFF : {s.acc[27:0], d[3:0]};
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/http_chunked_body_decoder_unit.sv =====
`default_nettype none

// Channel | Direction | Handshake            | Beat payload
// in      | input     | in_valid_i/in_ready_o | rx_byte_i, final_byte_i
// out     | output    | out_valid_o/out_ready_i | body_byte_o, has_byte_o, done_res_o,
//         |           |                      | end_kind_o, ws_overflow_o
//
// One input beat per cycle while it yields at most one result and the output slot is free.
// A flush of held whitespace streams N entries from the hold memory, one per cycle while the
// output slot is free, then any trailing body byte and done beat; input is held off meanwhile.
// The output register frees the input side while a result waits downstream.
// Reset (async, active low) returns to header search; the hold memory needs no clearing pass.

module http_chunked_body_decoder_unit #(
  parameter int unsigned HOLD_DEPTH = chbd_pkg::HoldDepthDef
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  input  wire  [7:0] rx_byte_i,
  input  wire        final_byte_i,
  output logic       out_valid_o,
  input  wire        out_ready_i,
  output logic [7:0] body_byte_o,
  output logic       has_byte_o,
  output logic       done_res_o,
  output logic [1:0] end_kind_o,
  output logic       ws_overflow_o
);
  import chbd_pkg::*;

  localparam int unsigned AW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
  localparam int unsigned CW = $clog2(HOLD_DEPTH + 1);
  localparam logic [CW-1:0] CntFull = CW'(HOLD_DEPTH);

  localparam logic [2:0] PhHeader = 3'd0;
  localparam logic [2:0] PhSize   = 3'd1;
  localparam logic [2:0] PhData   = 3'd2;
  localparam logic [2:0] PhSkip   = 3'd3;
  localparam logic [2:0] PhDone   = 3'd4;

  localparam logic [1:0] StIn    = 2'd0;
  localparam logic [1:0] StFlush = 2'd1;
  localparam logic [1:0] StByte  = 2'd2;
  localparam logic [1:0] StDone  = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [2:0]    phase_q, phase_d;
  logic [1:0]    hm_q, hm_d;
  size_t         sz_q, sz_d;
  logic          crp_q, crp_d;
  logic [31:0]   left_q, left_d;
  logic [1:0]    skip_q, skip_d;
  logic          bbeg_q, bbeg_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          ovf_q, ovf_d;

  logic [CW-1:0] fidx_q, fidx_d;
  logic [CW-1:0] fnum_q;
  logic [CW-1:0] fidx_inc;
  byte_t         pbyte_q;
  logic          pbyte_v_q, pdone_v_q, povf_q;
  logic [1:0]    pkind_q;

  logic          in_fire, can_push;
  logic          st_flush, st_byte, st_done, ovf_em;
  logic [1:0]    st_kind;
  logic [2:0]    hm_w;
  logic [1:0]    skip_t;
  logic [31:0]   left_t;
  size_t         sz_t;

  logic          mem_we, rd_en;
  logic [AW-1:0] mem_wa, rd_addr;
  byte_t         rd_data;

  logic          push, push_has, push_done, push_ovf;
  byte_t         push_byte;
  logic [1:0]    push_kind;

  logic          out_valid_q;
  byte_t         out_byte_q;
  logic          out_has_q, out_done_q, out_ovf_q;
  logic [1:0]    out_kind_q;

  assign in_ready_o = (state_q == StIn);
  assign in_fire    = in_valid_i && in_ready_o;
  assign can_push   = !out_valid_q || out_ready_i;
  assign fidx_inc   = fidx_q + CW'(1);

  chbd_hold_mem #(
    .Depth (HOLD_DEPTH),
    .AddrW (AW)
  ) u_hold (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_wa),
    .wdata_i (rx_byte_i),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // parse step for one input byte
  always_comb begin
    phase_d  = phase_q;
    hm_d     = hm_q;
    sz_d     = sz_q;
    crp_d    = crp_q;
    left_d   = left_q;
    skip_d   = skip_q;
    bbeg_d   = bbeg_q;
    cnt_d    = cnt_q;
    ovf_d    = ovf_q;
    st_flush = 1'b0;
    st_byte  = 1'b0;
    st_done  = 1'b0;
    st_kind  = EndZeroChunk;
    mem_we   = 1'b0;
    mem_wa   = cnt_q[AW-1:0];
    hm_w     = 3'd0;
    skip_t   = skip_q;
    left_t   = left_q;
    sz_t     = sz_q;

    unique case (phase_q)
      PhHeader: begin
        if (!hm_q[0]) begin
          hm_w = (rx_byte_i == ChCr) ? ({1'b0, hm_q} + 3'd1) : 3'd0;
        end else if (rx_byte_i == ChLf) begin
          hm_w = {1'b0, hm_q} + 3'd1;
        end else begin
          hm_w = (rx_byte_i == ChCr) ? 3'd1 : 3'd0;
        end
        hm_d = hm_w[1:0];
        if (hm_w[2]) begin
          hm_d    = 2'd0;
          phase_d = PhSize;
          sz_d    = '0;
          crp_d   = 1'b0;
        end
      end
      PhSize: begin
        if (crp_q && (rx_byte_i == ChLf)) begin
          if (sz_q.acc == 32'd0) begin
            phase_d = PhDone;
            st_done = 1'b1;
            st_kind = EndZeroChunk;
          end else begin
            left_d  = sz_q.acc;
            phase_d = PhData;
          end
          sz_d  = '0;
          crp_d = 1'b0;
        end else begin
          if (crp_q) begin
            sz_t = size_char(sz_q, ChCr);
          end
          crp_d = (rx_byte_i == ChCr);
          if (rx_byte_i != ChCr) begin
            sz_t = size_char(sz_t, rx_byte_i);
          end
          sz_d = sz_t;
        end
      end
      PhData: begin
        if (is_ws(rx_byte_i)) begin
          if (bbeg_q) begin
            mem_we = in_fire;
            if (cnt_q == CntFull) begin
              ovf_d    = 1'b1;
              st_flush = 1'b1;
              mem_wa   = '0;
              cnt_d    = CW'(1);
            end else begin
              cnt_d = cnt_q + CW'(1);
            end
          end
        end else begin
          st_flush = (cnt_q != '0);
          cnt_d    = '0;
          st_byte  = 1'b1;
          bbeg_d   = 1'b1;
        end
        left_t = left_q - 32'd1;
        left_d = left_t;
        if (left_t == 32'd0) begin
          phase_d = PhSkip;
          skip_d  = 2'd2;
        end
      end
      PhSkip: begin
        if (skip_q != 2'd0) begin
          skip_t = skip_q - 2'd1;
        end
        skip_d = skip_t;
        if (skip_t == 2'd0) begin
          phase_d = PhSize;
          sz_d    = '0;
          crp_d   = 1'b0;
        end
      end
      default: begin
      end
    endcase

    ovf_em = ovf_d;

    if (final_byte_i) begin
      if (phase_d != PhDone) begin
        st_done = 1'b1;
        st_kind = (phase_d == PhHeader) ? EndNoHeader : EndRanOut;
      end
      phase_d = PhHeader;
      hm_d    = 2'd0;
      sz_d    = '0;
      crp_d   = 1'b0;
      left_d  = 32'd0;
      skip_d  = 2'd0;
      bbeg_d  = 1'b0;
      cnt_d   = '0;
      ovf_d   = 1'b0;
    end
  end

  // result sequencer
  always_comb begin
    state_d   = state_q;
    fidx_d    = fidx_q;
    rd_en     = 1'b0;
    rd_addr   = '0;
    push      = 1'b0;
    push_byte = 8'h00;
    push_has  = 1'b0;
    push_done = 1'b0;
    push_kind = EndZeroChunk;
    push_ovf  = povf_q;

    unique case (state_q)
      StIn: begin
        if (in_fire) begin
          if (st_flush) begin
            rd_en   = 1'b1;
            fidx_d  = '0;
            state_d = StFlush;
          end else if (st_byte) begin
            if (can_push) begin
              push      = 1'b1;
              push_byte = rx_byte_i;
              push_has  = 1'b1;
              push_ovf  = ovf_em;
              state_d   = st_done ? StDone : StIn;
            end else begin
              state_d = StByte;
            end
          end else if (st_done) begin
            if (can_push) begin
              push      = 1'b1;
              push_done = 1'b1;
              push_kind = st_kind;
              push_ovf  = ovf_em;
            end else begin
              state_d = StDone;
            end
          end
        end
      end
      StFlush: begin
        if (can_push) begin
          push      = 1'b1;
          push_byte = rd_data;
          push_has  = 1'b1;
          fidx_d    = fidx_inc;
          if (fidx_inc == fnum_q) begin
            state_d = pbyte_v_q ? StByte : (pdone_v_q ? StDone : StIn);
          end else begin
            rd_en   = 1'b1;
            rd_addr = fidx_inc[AW-1:0];
          end
        end
      end
      StByte: begin
        if (can_push) begin
          push      = 1'b1;
          push_byte = pbyte_q;
          push_has  = 1'b1;
          state_d   = pdone_v_q ? StDone : StIn;
        end
      end
      StDone: begin
        if (can_push) begin
          push      = 1'b1;
          push_done = 1'b1;
          push_kind = pkind_q;
          state_d   = StIn;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIn;
      phase_q     <= PhHeader;
      hm_q        <= 2'd0;
      sz_q        <= '0;
      crp_q       <= 1'b0;
      left_q      <= 32'd0;
      skip_q      <= 2'd0;
      bbeg_q      <= 1'b0;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      fidx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fidx_q  <= fidx_d;
      if (in_fire) begin
        phase_q <= phase_d;
        hm_q    <= hm_d;
        sz_q    <= sz_d;
        crp_q   <= crp_d;
        left_q  <= left_d;
        skip_q  <= skip_d;
        bbeg_q  <= bbeg_d;
        cnt_q   <= cnt_d;
        ovf_q   <= ovf_d;
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pbyte_q   <= rx_byte_i;
      pbyte_v_q <= st_byte;
      pdone_v_q <= st_done;
      pkind_q   <= st_kind;
      povf_q    <= ovf_em;
      fnum_q    <= cnt_q;
    end
    if (push) begin
      out_byte_q <= push_byte;
      out_has_q  <= push_has;
      out_done_q <= push_done;
      out_kind_q <= push_kind;
      out_ovf_q  <= push_ovf;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign body_byte_o   = out_byte_q;
  assign has_byte_o    = out_has_q;
  assign done_res_o    = out_done_q;
  assign end_kind_o    = out_kind_q;
  assign ws_overflow_o = out_ovf_q;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntFull)
    else $error("hold count past depth");

  a_flush_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFlush) |-> (fidx_q < fnum_q))
    else $error("flush index past flush count");

  a_flush_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && st_flush) |=> (state_q == StFlush) && (fidx_q == '0))
    else $error("flush not started");

  a_skip_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhSkip) |-> (skip_q != 2'd0))
    else $error("skip phase with nothing left");

  a_result_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(has_byte_o && done_res_o))
    else $error("result both byte and done");
`endif

endmodule

`default_nettype wire

// ===== rtl/chbd_hold_mem.sv =====
`default_nettype none

module chbd_hold_mem #(
  parameter int unsigned Depth = 32,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire              clk_i,
  input  wire              we_i,
  input  wire  [AddrW-1:0] waddr_i,
  input  chbd_pkg::byte_t  wdata_i,
  input  wire              re_i,
  input  wire  [AddrW-1:0] raddr_i,
  output chbd_pkg::byte_t  rdata_o
);
  import chbd_pkg::*;

  byte_t mem [Depth];
  byte_t rdata_q;

  // read-during-write to the same entry returns the old contents
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
